// ===== hw/rtl/lcbc_pkg.sv =====
// Shared types, character codes and result expansion for the comment rewriter.
package lcbc_pkg;

  // Input and result items
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } lcbc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] status;
    logic       last;
  } lcbc_out_t;

  // Status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BLOCK_OPEN  = 2'd1;
  localparam logic [1:0] ST_STRING_OPEN = 2'd2;

  // Character codes
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Command queue depth
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Commands from the classifier to the emitter
  typedef enum logic [2:0] {
    OP_COPY,        // one byte as given
    OP_SPACE_SLASH, // " /"
    OP_LINE_END,    // " */\n"
    OP_STAR_SLASH,  // "*/"
    OP_STATUS       // bare status result
  } lcbc_op_t;

  typedef struct packed {
    lcbc_op_t   op;
    logic [7:0] data;
    logic [1:0] status;
  } lcbc_cmd_t;

  // Result number idx of a command's expansion
  function automatic lcbc_out_t lcbc_expand(input lcbc_cmd_t cmd, input logic [1:0] idx);
    lcbc_out_t r;
    r.out_byte   = 8'h00;
    r.byte_valid = 1'b1;
    r.status     = ST_OK;
    r.last       = 1'b0;
    unique case (cmd.op)
      OP_COPY: begin
        r.out_byte = cmd.data;
        r.last     = 1'b1;
      end
      OP_SPACE_SLASH: begin
        r.out_byte = (idx == 2'd0) ? CH_SPACE : CH_SLASH;
        r.last     = (idx != 2'd0);
      end
      OP_LINE_END: begin
        unique case (idx)
          2'd0: r.out_byte = CH_SPACE;
          2'd1: r.out_byte = CH_STAR;
          2'd2: r.out_byte = CH_SLASH;
          default: r.out_byte = CH_NEWLINE;
        endcase
        r.last = (idx == 2'd3);
      end
      OP_STAR_SLASH: begin
        r.out_byte = (idx == 2'd0) ? CH_STAR : CH_SLASH;
        r.last     = (idx != 2'd0);
      end
      default: begin
        r.byte_valid = 1'b0;
        r.status     = cmd.status;
        r.last       = 1'b1;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/lcbc_front.sv =====
// Classifier: tracks the scan mode and turns each item into an expansion command.
module lcbc_front import lcbc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  lcbc_in_t  in_item,
  input  logic      q_full,
  output logic      q_push,
  output lcbc_cmd_t q_cmd
);

  typedef enum logic [2:0] {
    MODE_CODE,
    MODE_SLASH,
    MODE_BLOCK,
    MODE_LINE,
    MODE_STR
  } mode_t;

  mode_t mode_r, mode_nxt;
  logic  star_r, star_nxt;
  logic [7:0] b;

  assign b      = in_item.in_byte;
  assign q_push = in_valid && !q_full;

  // Classify the item against the current mode
  always_comb begin
    mode_nxt     = MODE_CODE;
    star_nxt     = 1'b0;
    q_cmd.op     = OP_COPY;
    q_cmd.data   = b;
    q_cmd.status = ST_OK;
    if (in_item.end_of_input) begin
      q_cmd.op = OP_STATUS;
      unique case (mode_r)
        MODE_LINE:  q_cmd.op = OP_STAR_SLASH;
        MODE_BLOCK: q_cmd.status = ST_BLOCK_OPEN;
        MODE_STR:   q_cmd.status = ST_STRING_OPEN;
        default:    q_cmd.status = ST_OK;
      endcase
    end else begin
      unique case (mode_r)
        MODE_SLASH: begin
          if (b == CH_STAR) begin
            q_cmd.data = CH_STAR;
            mode_nxt   = MODE_BLOCK;
          end else if (b == CH_SLASH) begin
            q_cmd.data = CH_STAR;
            mode_nxt   = MODE_LINE;
          end
        end
        MODE_BLOCK: begin
          if (b == CH_SLASH && star_r) begin
            mode_nxt = MODE_CODE;
          end else begin
            mode_nxt = MODE_BLOCK;
            star_nxt = (b == CH_STAR);
          end
        end
        MODE_LINE: begin
          mode_nxt = MODE_LINE;
          if (b == CH_NEWLINE) begin
            q_cmd.op = OP_LINE_END;
            mode_nxt = MODE_CODE;
          end else if (b == CH_SLASH) begin
            if (star_r) q_cmd.op = OP_SPACE_SLASH;
          end else begin
            star_nxt = (b == CH_STAR);
          end
        end
        MODE_STR: begin
          mode_nxt = (b == CH_QUOTE) ? MODE_CODE : MODE_STR;
        end
        default: begin
          if (b == CH_SLASH)      mode_nxt = MODE_SLASH;
          else if (b == CH_QUOTE) mode_nxt = MODE_STR;
        end
      endcase
    end
  end

  // Advance the mode on each queued item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_CODE;
      star_r <= 1'b0;
    end else if (q_push) begin
      mode_r <= mode_nxt;
      star_r <= star_nxt;
    end
  end

endmodule

// ===== hw/rtl/lcbc_queue.sv =====
// Command queue between the classifier and the emitter.
module lcbc_queue import lcbc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  lcbc_cmd_t push_cmd,
  input  logic      pop,
  output logic      full,
  output logic      head_valid,
  output lcbc_cmd_t head_cmd
);

  lcbc_cmd_t          entries [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = entries[rd_ptr_r];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr_r] <= push_cmd;
  end

  // Move pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/lcbc_back.sv =====
// Emitter: expands the head command into result items, one per cycle while out_stall is low.
module lcbc_back import lcbc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  lcbc_cmd_t head_cmd,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output lcbc_out_t out_item
);

  logic [1:0] idx_r;
  logic       out_valid_r;
  lcbc_out_t  out_item_r;
  lcbc_out_t  res;
  logic       load;

  assign res       = lcbc_expand(head_cmd, idx_r);
  assign load      = !out_valid_r || !out_stall;
  assign pop       = load && head_valid && res.last;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Fill the output register and step through the expansion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (load) begin
      out_valid_r <= head_valid;
      if (head_valid) idx_r <= res.last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_item_r <= res;
  end

endmodule

// ===== hw/rtl/line_comment_to_block_comment.sv =====
// Top level of the line-comment to block-comment rewriter.
// Takes C source one byte per item and rewrites each line comment as a block
// comment; end_of_input closes the file, reports an open block comment or string
// in status, and resets the scanner. One item is accepted per cycle while the
// four-entry command queue has room; the emitter sends one result item per
// cycle while out_stall is low: a byte gives one result item, a line-comment
// end four and a slash after a star inside a line comment two. The single
// emitter port sets the sustained rate, and the queue absorbs short bursts
// of expansion. Results pass through the queue and the emitter output register.
module line_comment_to_block_comment import lcbc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  lcbc_in_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output lcbc_out_t out_item
);

  logic      q_full;
  logic      q_push;
  lcbc_cmd_t q_cmd;
  logic      q_pop;
  logic      head_valid;
  lcbc_cmd_t head_cmd;

  assign in_stall = q_full;

  lcbc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  lcbc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  lcbc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

`ifndef SYNTHESIS
  // A bare status result always closes its item
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.byte_valid |-> out_item.last)
    else $error("status result without last");

  // Nonzero status only on bare results
  a_status_bare: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |-> !out_item.byte_valid)
    else $error("status on byte result");

  // The emitter only pops a queue that holds a command
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> head_valid)
    else $error("pop from empty queue");

  // An accepted item always lands in the queue
  a_accept_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> q_push)
    else $error("accepted item not queued");
`endif

endmodule
